@@ rtl/core/cfm_pkg.sv @@
// ----------------------------------------------------------------------------
// cfm_pkg
// Shared types and constants of the GF(2^255-19) field multiplier.
// ----------------------------------------------------------------------------
package cfm_pkg;

   localparam int unsigned LIMB_WIDTH    = 26;
   localparam int unsigned PRODUCT_WIDTH = 27;
   localparam int unsigned ADDR_WIDTH    = 4;
   localparam int unsigned MUL_WIDTH     = 2 * LIMB_WIDTH;
   localparam int unsigned ACC_WIDTH     = 64;
   localparam int unsigned CARRY_WIDTH   = ACC_WIDTH - 25;

   localparam logic [ADDR_WIDTH-1:0] LIMB_COUNT = 4'd10;
   localparam logic [ADDR_WIDTH-1:0] LIMB_LAST  = 4'd9;

   typedef struct packed {
      logic [LIMB_WIDTH-1:0] left_limb;
      logic [LIMB_WIDTH-1:0] right_limb;
      logic                  last_limb;
   } req_payload_type;

   typedef struct packed {
      logic [PRODUCT_WIDTH-1:0] product_limb;
      logic                     final_limb;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FOLD,
      ST_CARRY0,
      ST_CARRY1,
      ST_EMIT
   } state_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic                  load_en;
      logic [ADDR_WIDTH-1:0] load_addr;
      logic                  clear_carry;
      logic                  mac_en;
      logic [ADDR_WIDTH-1:0] mac_left_addr;
      logic [ADDR_WIDTH-1:0] mac_right_addr;
      logic                  mac_wrap;
      logic                  mac_double;
      logic                  mac_first;
      logic                  mac_last;
      logic [ADDR_WIDTH-1:0] mac_col;
      logic                  fold_en;
      logic                  carry0_en;
      logic                  carry1_en;
      logic                  emit_en;
      logic [ADDR_WIDTH-1:0] emit_addr;
      logic                  emit_final;
   } cmd_type;

endpackage

@@ rtl/core/cfm_controller.sv @@
// ----------------------------------------------------------------------------
// cfm_controller
// Sequencer: limb loading, column-major multiply-accumulate order, final
// carry steps and result emission.
// ----------------------------------------------------------------------------
module cfm_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     last_limb,
   output logic                     busy,
   output cfm_pkg::cmd_type         cmd
);

   cfm_pkg::state_type state_ff, state_in;
   logic [cfm_pkg::ADDR_WIDTH-1:0] load_pos_ff, load_pos_in;
   logic [cfm_pkg::ADDR_WIDTH-1:0] col_ff, col_in;
   logic [cfm_pkg::ADDR_WIDTH-1:0] row_ff, row_in;
   logic [cfm_pkg::ADDR_WIDTH-1:0] emit_ff, emit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cfm_pkg::ST_IDLE;
         load_pos_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         emit_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         load_pos_ff <= load_pos_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         emit_ff     <= emit_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      load_pos_in = load_pos_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      emit_in     = emit_ff;
      cmd         = '0;
      busy        = (state_ff != cfm_pkg::ST_IDLE);

      // column term: right index wraps around the ring
      cmd.mac_left_addr  = row_ff;
      cmd.mac_right_addr = (col_ff >= row_ff) ? (col_ff - row_ff)
                                              : (col_ff + cfm_pkg::LIMB_COUNT - row_ff);
      cmd.mac_wrap       = (row_ff > col_ff);
      cmd.mac_double     = row_ff[0] & cmd.mac_right_addr[0];
      cmd.mac_first      = (row_ff == '0);
      cmd.mac_last       = (row_ff == cfm_pkg::LIMB_LAST);
      cmd.mac_col        = col_ff;
      cmd.load_addr      = load_pos_ff;
      cmd.emit_addr      = emit_ff;
      cmd.emit_final     = (emit_ff == cfm_pkg::LIMB_LAST);

      unique case (state_ff)
         cfm_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load_en = (load_pos_ff < cfm_pkg::LIMB_COUNT);
               if (last_limb) begin
                  load_pos_in     = '0;
                  cmd.clear_carry = 1'b1;
                  col_in          = '0;
                  row_in          = '0;
                  state_in        = cfm_pkg::ST_MAC;
               end else if (load_pos_ff < cfm_pkg::LIMB_COUNT) begin
                  load_pos_in = load_pos_ff + 1'b1;
               end
            end
         end
         cfm_pkg::ST_MAC: begin
            cmd.mac_en = 1'b1;
            if (row_ff == cfm_pkg::LIMB_LAST) begin
               row_in = '0;
               if (col_ff == cfm_pkg::LIMB_LAST) begin
                  state_in = cfm_pkg::ST_DRAIN;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         cfm_pkg::ST_DRAIN: begin
            state_in = cfm_pkg::ST_FOLD;
         end
         cfm_pkg::ST_FOLD: begin
            cmd.fold_en = 1'b1;
            state_in    = cfm_pkg::ST_CARRY0;
         end
         cfm_pkg::ST_CARRY0: begin
            cmd.carry0_en = 1'b1;
            state_in      = cfm_pkg::ST_CARRY1;
         end
         cfm_pkg::ST_CARRY1: begin
            cmd.carry1_en = 1'b1;
            emit_in       = '0;
            state_in      = cfm_pkg::ST_EMIT;
         end
         cfm_pkg::ST_EMIT: begin
            cmd.emit_en = 1'b1;
            if (emit_ff == cfm_pkg::LIMB_LAST) begin
               state_in = cfm_pkg::ST_IDLE;
            end else begin
               emit_in = emit_ff + 1'b1;
            end
         end
         default: begin
            state_in = cfm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/cfm_datapath.sv @@
// ----------------------------------------------------------------------------
// cfm_datapath
// Operand stores, shared 26x26 multiplier, weighted accumulator with
// per-column carry, result limb store and output register.
// ----------------------------------------------------------------------------
module cfm_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  cfm_pkg::cmd_type         cmd,
   input  cfm_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output cfm_pkg::rsp_payload_type rsp_payload
);

   localparam int unsigned W19_WIDTH  = cfm_pkg::MUL_WIDTH + 5;
   localparam int unsigned F19_WIDTH  = cfm_pkg::CARRY_WIDTH + 5;
   localparam int unsigned FOLD_WIDTH = F19_WIDTH + 1;

   logic [cfm_pkg::LIMB_WIDTH-1:0]    left_mem  [10];
   logic [cfm_pkg::LIMB_WIDTH-1:0]    right_mem [10];
   logic [cfm_pkg::PRODUCT_WIDTH-1:0] limb_mem  [10];

   logic [cfm_pkg::MUL_WIDTH-1:0]   prod_ff;
   logic                            prod_valid_ff;
   logic                            prod_wrap_ff;
   logic                            prod_double_ff;
   logic                            prod_first_ff;
   logic                            prod_last_ff;
   logic [cfm_pkg::ADDR_WIDTH-1:0]  prod_col_ff;
   logic [cfm_pkg::ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [cfm_pkg::CARRY_WIDTH-1:0] carry_ff;
   logic                            strobe_ff;
   cfm_pkg::rsp_payload_type        out_ff;

   logic [W19_WIDTH-1:0]            prod_x19;
   logic [W19_WIDTH:0]              weighted;
   logic [cfm_pkg::ACC_WIDTH-1:0]   acc_base;
   logic [F19_WIDTH-1:0]            carry_x19;
   logic [FOLD_WIDTH-1:0]           fold_sum;
   logic [cfm_pkg::CARRY_WIDTH:0]   carry0_sum;

   always_comb begin
      prod_x19 = ({5'b0, prod_ff} << 4) + ({5'b0, prod_ff} << 1) + {5'b0, prod_ff};
      unique case ({prod_wrap_ff, prod_double_ff})
         2'b00:   weighted = {6'b0, prod_ff};
         2'b01:   weighted = {5'b0, prod_ff, 1'b0};
         2'b10:   weighted = {1'b0, prod_x19};
         default: weighted = {prod_x19, 1'b0};
      endcase
      acc_base = prod_first_ff ? {{(cfm_pkg::ACC_WIDTH-cfm_pkg::CARRY_WIDTH){1'b0}}, carry_ff}
                               : acc_ff;
      acc_in   = acc_base + {{(cfm_pkg::ACC_WIDTH-W19_WIDTH-1){1'b0}}, weighted};

      carry_x19  = ({5'b0, carry_ff} << 4) + ({5'b0, carry_ff} << 1) + {5'b0, carry_ff};
      fold_sum   = {1'b0, carry_x19}
                 + {{(FOLD_WIDTH-26){1'b0}}, limb_mem[0][25:0]};
      carry0_sum = {1'b0, carry_ff}
                 + {{(cfm_pkg::CARRY_WIDTH+1-25){1'b0}}, limb_mem[1][24:0]};
   end

   // operand stores and multiplier stage
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         left_mem[cmd.load_addr]  <= req_payload.left_limb;
         right_mem[cmd.load_addr] <= req_payload.right_limb;
      end
      prod_ff        <= left_mem[cmd.mac_left_addr] * right_mem[cmd.mac_right_addr];
      prod_wrap_ff   <= cmd.mac_wrap;
      prod_double_ff <= cmd.mac_double;
      prod_first_ff  <= cmd.mac_first;
      prod_last_ff   <= cmd.mac_last;
      prod_col_ff    <= cmd.mac_col;
   end

   // accumulator, column carry, final carry steps and output register
   always_ff @(posedge clock) begin
      if (prod_valid_ff) begin
         acc_ff <= acc_in;
      end
      priority if (cmd.clear_carry) begin
         carry_ff <= '0;
      end else if (prod_valid_ff && prod_last_ff) begin
         if (prod_col_ff[0]) begin
            limb_mem[prod_col_ff] <= {2'b0, acc_in[24:0]};
            carry_ff              <= acc_in[cfm_pkg::ACC_WIDTH-1:25];
         end else begin
            limb_mem[prod_col_ff] <= {1'b0, acc_in[25:0]};
            carry_ff              <= {1'b0, acc_in[cfm_pkg::ACC_WIDTH-1:26]};
         end
      end else if (cmd.fold_en) begin
         limb_mem[0] <= {1'b0, fold_sum[25:0]};
         carry_ff    <= {{(cfm_pkg::CARRY_WIDTH-(FOLD_WIDTH-26)){1'b0}},
                         fold_sum[FOLD_WIDTH-1:26]};
      end else if (cmd.carry0_en) begin
         limb_mem[1] <= {2'b0, carry0_sum[24:0]};
         carry_ff    <= {{(cfm_pkg::CARRY_WIDTH-(cfm_pkg::CARRY_WIDTH+1-25)){1'b0}},
                         carry0_sum[cfm_pkg::CARRY_WIDTH:25]};
      end else if (cmd.carry1_en) begin
         limb_mem[2] <= limb_mem[2] + carry_ff[cfm_pkg::PRODUCT_WIDTH-1:0];
      end else begin
         // hold carry and limbs
      end
      if (cmd.emit_en) begin
         out_ff.product_limb <= limb_mem[cmd.emit_addr];
         out_ff.final_limb   <= cmd.emit_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.mac_en;
         strobe_ff     <= cmd.emit_en;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = out_ff;

endmodule

@@ rtl/core/curve25519_field_multiply.sv @@
// ----------------------------------------------------------------------------
// curve25519_field_multiply
// Results: product limb 0 reaches the result ports after the request carrying
//   limb 9 is accepted and the MAC, drain, fold, CARRY0 and CARRY1 states have
//   run, then ten strobes follow on consecutive cycles (limb 0 to 9).
// Throughput: one request per cycle while loading; a full run occupies the
//   single 26x26 multiplier for 100 multiply-accumulates, plus carry fixup
//   and emission, and no new multiply is taken until the run ends (busy).
// Reset: synchronous, clears the sequencer and load position; operand stores
//   are undefined until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module curve25519_field_multiply (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  cfm_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output cfm_pkg::rsp_payload_type rsp_payload
);

   // Sequencer to datapath commands
   cfm_pkg::cmd_type cmd;

   // Controller: counts limb requests while idle, walks the 10x10 product
   // terms column by column, then steps the ring carry and emission.
   cfm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_limb (req_payload.last_limb),
      .busy      (busy),
      .cmd       (cmd)
   );

   // Datapath: hold operand limbs, multiply one term per cycle, accumulate
   // each column on top of the previous column's carry, and drive results.
   cfm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // A request flagged last starts a multiply: block further requests
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.last_limb) |=> busy)
      else $error("multiply did not start after last limb");

   // Product limbs arrive on consecutive cycles until the final one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.final_limb) |=> rsp_strobe)
      else $error("gap inside a result run");

   // The final limb ends the run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.final_limb) |=> !rsp_strobe)
      else $error("result after final limb");

   // Busy only rises on a request that carries the last limb
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_payload.last_limb))
      else $error("busy without a last-limb request");

endmodule
